// File: rtl/core/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip chart framebuffer package
// Screen geometry, derived widths, codes and shared types.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;

    localparam int STORE_PAGES  = SCREEN_ROWS / 8;
    localparam int STORE_BYTES  = SCREEN_COLUMNS * STORE_PAGES;
    localparam int STORE_ADDR_W = $clog2(STORE_BYTES);
    localparam int IDX_W        = STORE_ADDR_W + 1;
    localparam int COL_W        = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W        = $clog2(SCREEN_ROWS);
    localparam int HEIGHT_W     = $clog2(SCREEN_ROWS + 1);
    localparam int HALF_ROWS    = SCREEN_ROWS / 2;
    localparam int HALF_PAGES   = STORE_PAGES / 2;

    localparam int SAMPLE_W    = 16;
    localparam int DIVD_W      = SAMPLE_W + HEIGHT_W;
    localparam int DIV_CNT_W   = $clog2(DIVD_W);
    localparam int READ_ADDR_W = 10;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int REGION_W    = 2;

    // Byte ranges walked by a scroll
    localparam int FULL_LAST    = STORE_BYTES - 1;
    localparam int TOP_LAST     = HALF_PAGES * SCREEN_COLUMNS - 1;
    localparam int BOTTOM_FIRST = STORE_BYTES / 2;
    localparam int BOTTOM_LAST  = BOTTOM_FIRST + HALF_PAGES * SCREEN_COLUMNS - 1;

    localparam int FULL_SCALE_RESET = 4096;

    typedef logic [STORE_ADDR_W-1:0] store_addr_t;
    typedef logic [IDX_W-1:0]        store_idx_t;
    typedef logic [COL_W-1:0]        col_t;
    typedef logic [ROW_W-1:0]        row_t;
    typedef logic [DIVD_W-1:0]       dvd_t;
    typedef logic [SAMPLE_W-1:0]     sample_t;
    typedef logic [DIV_CNT_W-1:0]    div_cnt_t;
    typedef logic [BYTE_W-1:0]       byte_t;

    // Region codes; any other code selects the top half
    localparam logic [REGION_W-1:0] REGION_FULL   = 2'd0;
    localparam logic [REGION_W-1:0] REGION_BOTTOM = 2'd2;

    localparam logic REQ_READ = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PLOT_ENABLE = 2'd0,
        CFG_FULL_SCALE  = 2'd1,
        CFG_PLOT_REGION = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PRIME,
        ST_SCROLL,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_READ,
        ST_READ_DATA
    } state_t;

    typedef struct packed {
        logic        wr_en;
        store_addr_t wr_addr;
        byte_t       wr_data;
        store_addr_t rd_addr;
    } mem_req_t;

endpackage

// File: rtl/core/scrolling_strip_chart_framebuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling strip chart framebuffer
// Scales samples to a row, scrolls the plot region left one column and sets
// the new pixel; read requests return one packed store byte.
// ----------------------------------------------------------------------------
// Reset: a clearing pass writes zero to all STORE_BYTES (1024) store bytes,
// one per cycle; no item is taken until it ends. Config writes land in any state once reset is released.
// Push: the accept cycle starts the divider (DIVD_W steps and a handoff), a prime state
// primes the read, one scrolled byte per cycle (1024 full screen, 512 half) goes through
// the single memory port, and a read and a write draw the pixel. A disabled push is dropped.
// Read: the store read and then the output register; a stalled sink holds the result back.
module scrolling_strip_chart_framebuffer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]     cfg_addr,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [ssc_pkg::SAMPLE_W-1:0]        s_sample_value,
    input  logic [ssc_pkg::READ_ADDR_W-1:0]     s_read_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ssc_pkg::BYTE_W-1:0]          m_read_byte
);

    ssc_pkg::state_t      state_reg, state_next;
    logic                 plot_enable_reg;
    ssc_pkg::sample_t     full_scale_reg;
    logic [ssc_pkg::REGION_W-1:0] plot_region_reg;

    ssc_pkg::store_addr_t idx_reg, idx_next;
    ssc_pkg::store_addr_t last_reg, last_next;
    ssc_pkg::col_t        col_reg, col_next;
    ssc_pkg::row_t        hm1_reg, hm1_next;
    ssc_pkg::row_t        pix_off_reg, pix_off_next;
    ssc_pkg::store_addr_t draw_idx_reg, draw_idx_next;
    logic                 draw_ok_reg, draw_ok_next;
    logic [2:0]           draw_bit_reg, draw_bit_next;
    logic [ssc_pkg::READ_ADDR_W-1:0] addr_reg, addr_next;
    logic                 addr_ok_reg, addr_ok_next;
    logic                 m_valid_reg, m_valid_next;
    ssc_pkg::byte_t       m_read_byte_reg, m_read_byte_next;

    ssc_pkg::mem_req_t    mem_req;
    ssc_pkg::byte_t       rd_data;
    logic                 div_start;
    logic                 div_done;
    ssc_pkg::dvd_t        div_quotient;
    ssc_pkg::dvd_t        dividend;
    ssc_pkg::dvd_t        height;
    logic                 region_full;
    logic                 region_bottom;
    ssc_pkg::row_t        row;
    ssc_pkg::row_t        y;
    ssc_pkg::store_idx_t  pix_idx;
    logic                 col_last;
    logic                 accept;

    assign accept        = s_valid && s_ready;
    assign s_ready       = (state_reg == ssc_pkg::ST_IDLE);
    assign region_full   = (plot_region_reg == ssc_pkg::REGION_FULL);
    assign region_bottom = (plot_region_reg == ssc_pkg::REGION_BOTTOM);
    assign height        = region_full ? ssc_pkg::dvd_t'(ssc_pkg::SCREEN_ROWS)
                                       : ssc_pkg::dvd_t'(ssc_pkg::HALF_ROWS);
    assign dividend      = height * ssc_pkg::dvd_t'(s_sample_value);
    assign col_last      = (col_reg == ssc_pkg::col_t'(ssc_pkg::SCREEN_COLUMNS - 1));

    // Clamp the quotient and locate the pixel in the right column
    assign row = (div_quotient > ssc_pkg::dvd_t'(hm1_reg)) ? hm1_reg
                                                           : ssc_pkg::row_t'(div_quotient);
    assign y   = pix_off_reg + hm1_reg - row;
    assign pix_idx = ssc_pkg::store_idx_t'(y >> 3)
                   * ssc_pkg::store_idx_t'(ssc_pkg::SCREEN_COLUMNS)
                   + ssc_pkg::store_idx_t'(ssc_pkg::SCREEN_COLUMNS - 1);

    ssc_row_div u_row_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (full_scale_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ssc_frame_store u_frame_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssc_pkg::ST_CLEAR: begin
                if (idx_reg == ssc_pkg::store_addr_t'(ssc_pkg::FULL_LAST)) begin
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            ssc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == ssc_pkg::REQ_READ) begin
                        state_next = ssc_pkg::ST_READ;
                    end else if (plot_enable_reg) begin
                        state_next = ssc_pkg::ST_DIV;
                    end
                end
            end
            ssc_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = ssc_pkg::ST_PRIME;
                end
            end
            ssc_pkg::ST_PRIME: begin
                state_next = ssc_pkg::ST_SCROLL;
            end
            ssc_pkg::ST_SCROLL: begin
                if (idx_reg == last_reg) begin
                    state_next = ssc_pkg::ST_DRAW_RD;
                end
            end
            ssc_pkg::ST_DRAW_RD: begin
                state_next = draw_ok_reg ? ssc_pkg::ST_DRAW_WR : ssc_pkg::ST_IDLE;
            end
            ssc_pkg::ST_DRAW_WR: begin
                state_next = ssc_pkg::ST_IDLE;
            end
            ssc_pkg::ST_READ: begin
                state_next = ssc_pkg::ST_READ_DATA;
            end
            ssc_pkg::ST_READ_DATA: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory port
    always_comb begin
        mem_req          = '0;
        mem_req.rd_addr  = idx_reg;
        div_start        = 1'b0;
        idx_next         = idx_reg;
        last_next        = last_reg;
        col_next         = col_reg;
        hm1_next         = hm1_reg;
        pix_off_next     = pix_off_reg;
        draw_idx_next    = draw_idx_reg;
        draw_ok_next     = draw_ok_reg;
        draw_bit_next    = draw_bit_reg;
        addr_next        = addr_reg;
        addr_ok_next     = addr_ok_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_read_byte_next = m_read_byte_reg;
        unique case (state_reg)
            ssc_pkg::ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = '0;
                idx_next        = idx_reg + 1'b1;
            end
            ssc_pkg::ST_IDLE: begin
                if (accept && s_req_type == ssc_pkg::REQ_READ) begin
                    addr_next    = s_read_address;
                    addr_ok_next = 32'(s_read_address) < ssc_pkg::STORE_BYTES;
                end else if (accept && plot_enable_reg) begin
                    div_start = 1'b1;
                    col_next  = '0;
                    if (region_full) begin
                        idx_next     = '0;
                        last_next    = ssc_pkg::store_addr_t'(ssc_pkg::FULL_LAST);
                        hm1_next     = ssc_pkg::row_t'(ssc_pkg::SCREEN_ROWS - 1);
                        pix_off_next = '0;
                    end else if (region_bottom) begin
                        idx_next     = ssc_pkg::store_addr_t'(ssc_pkg::BOTTOM_FIRST);
                        last_next    = ssc_pkg::store_addr_t'(ssc_pkg::BOTTOM_LAST);
                        hm1_next     = ssc_pkg::row_t'(ssc_pkg::HALF_ROWS - 1);
                        pix_off_next = ssc_pkg::row_t'(ssc_pkg::HALF_ROWS);
                    end else begin
                        idx_next     = '0;
                        last_next    = ssc_pkg::store_addr_t'(ssc_pkg::TOP_LAST);
                        hm1_next     = ssc_pkg::row_t'(ssc_pkg::HALF_ROWS - 1);
                        pix_off_next = '0;
                    end
                end
            end
            ssc_pkg::ST_DIV: begin
                if (div_done) begin
                    draw_idx_next = ssc_pkg::store_addr_t'(pix_idx);
                    draw_ok_next  = pix_idx < ssc_pkg::store_idx_t'(ssc_pkg::STORE_BYTES);
                    draw_bit_next = y[2:0];
                end
            end
            ssc_pkg::ST_PRIME: begin
                mem_req.rd_addr = idx_reg + 1'b1;
            end
            ssc_pkg::ST_SCROLL: begin
                // write byte idx from idx+1 while fetching idx+2
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = (col_last ||
                                   idx_reg == ssc_pkg::store_addr_t'(ssc_pkg::FULL_LAST))
                                  ? '0 : rd_data;
                mem_req.rd_addr = idx_reg + ssc_pkg::store_addr_t'(2);
                idx_next        = idx_reg + 1'b1;
                col_next        = col_last ? '0 : col_reg + 1'b1;
            end
            ssc_pkg::ST_DRAW_RD: begin
                mem_req.rd_addr = draw_idx_reg;
            end
            ssc_pkg::ST_DRAW_WR: begin
                mem_req.rd_addr = draw_idx_reg;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = draw_idx_reg;
                mem_req.wr_data = rd_data | (ssc_pkg::byte_t'(1) << draw_bit_reg);
            end
            ssc_pkg::ST_READ: begin
                mem_req.rd_addr = ssc_pkg::store_addr_t'(addr_reg);
            end
            ssc_pkg::ST_READ_DATA: begin
                // hold the read address until the output register frees up
                mem_req.rd_addr = ssc_pkg::store_addr_t'(addr_reg);
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_read_byte_next = addr_ok_reg ? rd_data : '0;
                end
            end
            default: begin
                mem_req.rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ssc_pkg::ST_CLEAR;
            idx_reg         <= '0;
            col_reg         <= '0;
            m_valid_reg     <= 1'b0;
            plot_enable_reg <= 1'b0;
            full_scale_reg  <= ssc_pkg::sample_t'(ssc_pkg::FULL_SCALE_RESET);
            plot_region_reg <= ssc_pkg::REGION_FULL;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    ssc_pkg::CFG_PLOT_ENABLE: plot_enable_reg <= cfg_wr_data[0];
                    ssc_pkg::CFG_FULL_SCALE:  full_scale_reg  <= cfg_wr_data;
                    ssc_pkg::CFG_PLOT_REGION:
                        plot_region_reg <= cfg_wr_data[ssc_pkg::REGION_W-1:0];
                    default: ;
                endcase
            end
        end
        last_reg        <= last_next;
        hm1_reg         <= hm1_next;
        pix_off_reg     <= pix_off_next;
        draw_idx_reg    <= draw_idx_next;
        draw_ok_reg     <= draw_ok_next;
        draw_bit_reg    <= draw_bit_next;
        addr_reg        <= addr_next;
        addr_ok_reg     <= addr_ok_next;
        m_read_byte_reg <= m_read_byte_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;

    // The store is left alone while waiting for an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssc_pkg::ST_IDLE) |-> !mem_req.wr_en)
        else $error("store written while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ssc_pkg::ST_DIV))
        else $error("divider finished outside a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssc_pkg::ST_SCROLL) |-> (idx_reg <= last_reg))
        else $error("scroll ran past its region");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ssc_pkg::ST_READ_DATA))
        else $error("result raised without a read");

endmodule

// File: rtl/core/ssc_row_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
module ssc_row_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  ssc_pkg::dvd_t    dividend,
    input  ssc_pkg::sample_t divisor,
    output logic             done,
    output ssc_pkg::dvd_t    quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    ssc_pkg::div_cnt_t   cnt_reg, cnt_next;
    ssc_pkg::sample_t    rem_reg, rem_next;
    ssc_pkg::dvd_t       quo_reg, quo_next;
    logic [ssc_pkg::SAMPLE_W:0] shifted;
    logic                fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[ssc_pkg::DIVD_W-1]};
        fits      = shifted >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // for a nonzero divisor the remainder stays below it, so the top bit drops
            rem_next = fits ? ssc_pkg::sample_t'(shifted - {1'b0, divisor})
                            : ssc_pkg::sample_t'(shifted);
            quo_next = {quo_reg[ssc_pkg::DIVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ssc_pkg::div_cnt_t'(ssc_pkg::DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/ssc_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Packed pixel memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssc_frame_store (
    input  logic              aclk,
    input  ssc_pkg::mem_req_t mem_req,
    output ssc_pkg::byte_t    rd_data
);

    ssc_pkg::byte_t frame_mem [ssc_pkg::STORE_BYTES];
    ssc_pkg::byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            frame_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= frame_mem[mem_req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip chart framebuffer testbench
// Drives sample pushes and byte reads through the valid/ready channels under
// random source gaps and sink stalls, keeps a shadow frame store that scrolls
// and draws as the block should, and checks every returned byte in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int   SETTLE_CYCLES  = 1200;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   PHASE_ITEMS    = 64;
    localparam logic REQ_PUSH       = ~ssc_pkg::REQ_READ;

    typedef logic [ssc_pkg::READ_ADDR_W-1:0] rd_addr_t;
    typedef logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic                 req;
        ssc_pkg::sample_t     smp;
        rd_addr_t             addr;
        bit                   has_exp;
        ssc_pkg::byte_t       exp_byte;
        ssc_pkg::cfg_index_t  reg_idx;
        cfg_data_t            reg_val;
    } stim_row_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                cfg_wr_en      = 1'b0;
    logic [ssc_pkg::CFG_INDEX_W-1:0]     cfg_addr       = '0;
    cfg_data_t                           cfg_wr_data    = '0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic                                s_req_type     = 1'b0;
    logic [ssc_pkg::SAMPLE_W-1:0]        s_sample_value = '0;
    rd_addr_t                            s_read_address = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [ssc_pkg::BYTE_W-1:0]          m_read_byte;

    // Shadow of the block: frame store and registers
    ssc_pkg::byte_t                      fb_model [ssc_pkg::STORE_BYTES];
    logic                                shadow_enable;
    cfg_data_t                           shadow_scale;
    logic [ssc_pkg::REGION_W-1:0]        shadow_region;

    ssc_pkg::byte_t                      read_byte_q [$];
    stim_row_t                           dir_tab [$];

    int                                  err_count    = 0;
    int                                  reads_sent   = 0;
    int                                  pushes_sent  = 0;
    int                                  pushes_drawn = 0;
    int                                  results_seen = 0;
    int                                  settings_run = 0;
    int                                  src_pct      = 15;
    int                                  sink_pct     = 15;
    int                                  sink_hold    = 0;
    int                                  quiet_cycles = 0;
    ssc_pkg::byte_t                      want_byte;

    scrolling_strip_chart_framebuffer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_sample_value (s_sample_value),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_byte    (m_read_byte)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s, got %02h, want %02h", $time, what, got, want);
        err_count++;
    endtask

    // Scroll a run of pages left by one column, zero-filling the right column
    function automatic void scroll_pages(input int unsigned first, input int unsigned pages);
        int unsigned idx;
        for (int unsigned p = 0; p < pages; p++) begin
            for (int unsigned c = 0; c < ssc_pkg::SCREEN_COLUMNS; c++) begin
                idx = first + p * ssc_pkg::SCREEN_COLUMNS + c;
                if (idx < ssc_pkg::STORE_BYTES) begin
                    if (c == ssc_pkg::SCREEN_COLUMNS - 1 || idx + 1 >= ssc_pkg::STORE_BYTES)
                        fb_model[idx] = '0;
                    else
                        fb_model[idx] = fb_model[idx + 1];
                end
            end
        end
    endfunction

    function automatic void draw_sample(input ssc_pkg::sample_t smp);
        int unsigned height, pages, offset, first, row, y, idx;
        height = (shadow_region == ssc_pkg::REGION_FULL) ? ssc_pkg::SCREEN_ROWS
                                                         : ssc_pkg::HALF_ROWS;
        pages  = (shadow_region == ssc_pkg::REGION_FULL) ? ssc_pkg::STORE_PAGES
                                                         : ssc_pkg::HALF_PAGES;
        offset = (shadow_region == ssc_pkg::REGION_BOTTOM) ? ssc_pkg::HALF_ROWS : 0;
        first  = (shadow_region == ssc_pkg::REGION_BOTTOM) ? ssc_pkg::BOTTOM_FIRST : 0;
        if (shadow_scale == 0) begin
            row = height - 1;
        end else begin
            row = (height * int'(smp)) / int'(shadow_scale);
            if (row > height - 1)
                row = height - 1;
        end
        scroll_pages(first, pages);
        y   = offset + height - 1 - row;
        idx = (y / 8) * ssc_pkg::SCREEN_COLUMNS + (ssc_pkg::SCREEN_COLUMNS - 1);
        if (idx < ssc_pkg::STORE_BYTES)
            fb_model[idx] = fb_model[idx] | ssc_pkg::byte_t'(1 << (y % 8));
    endfunction

    task automatic write_reg(input ssc_pkg::cfg_index_t idx, input cfg_data_t val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            ssc_pkg::CFG_PLOT_ENABLE: shadow_enable = val[0];
            ssc_pkg::CFG_FULL_SCALE:  shadow_scale  = val;
            ssc_pkg::CFG_PLOT_REGION: shadow_region = val[ssc_pkg::REGION_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait out all reads, then give a trailing push time to finish
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (read_byte_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(input logic req, input ssc_pkg::sample_t smp,
                             input rd_addr_t addr,
                             input bit has_exp, input ssc_pkg::byte_t exp_byte);
        int unsigned gap;
        @(negedge aclk);
        if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_sample_value <= smp;
        s_read_address <= addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // transfer taken at this edge
        if (req == ssc_pkg::REQ_READ) begin
            reads_sent++;
            if (has_exp)
                read_byte_q.push_back(exp_byte);
            else
                read_byte_q.push_back((addr < ssc_pkg::STORE_BYTES) ? fb_model[addr]
                                                                    : ssc_pkg::byte_t'(0));
        end else begin
            pushes_sent++;
            if (shadow_enable) begin
                draw_sample(smp);
                pushes_drawn++;
            end
        end
    endtask

    function automatic stim_row_t mk_read(input int addr, input bit has_exp,
                                          input ssc_pkg::byte_t val);
        stim_row_t r;
        r.kind     = ROW_ITEM;
        r.req      = ssc_pkg::REQ_READ;
        r.smp      = '0;
        r.addr     = addr[ssc_pkg::READ_ADDR_W-1:0];
        r.has_exp  = has_exp;
        r.exp_byte = val;
        r.reg_idx  = ssc_pkg::CFG_PLOT_ENABLE;
        r.reg_val  = '0;
        return r;
    endfunction

    function automatic stim_row_t mk_push(input int smp);
        stim_row_t r;
        r.kind     = ROW_ITEM;
        r.req      = REQ_PUSH;
        r.smp      = smp[ssc_pkg::SAMPLE_W-1:0];
        r.addr     = '0;
        r.has_exp  = 1'b0;
        r.exp_byte = '0;
        r.reg_idx  = ssc_pkg::CFG_PLOT_ENABLE;
        r.reg_val  = '0;
        return r;
    endfunction

    function automatic stim_row_t mk_cfg(input ssc_pkg::cfg_index_t idx, input int val);
        stim_row_t r;
        r.kind     = ROW_CFG;
        r.req      = REQ_PUSH;
        r.smp      = '0;
        r.addr     = '0;
        r.has_exp  = 1'b0;
        r.exp_byte = '0;
        r.reg_idx  = idx;
        r.reg_val  = val[ssc_pkg::CFG_DATA_W-1:0];
        return r;
    endfunction

    task automatic build_directed();
        dir_tab.push_back(mk_read(0, 1, 8'h00));                 // cleared after reset
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 1, 1, 8'h00));
        dir_tab.push_back(mk_push(100));                        // disabled: ignored
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 1, 1, 8'h00));
        dir_tab.push_back(mk_cfg(ssc_pkg::CFG_PLOT_ENABLE, 1));
        dir_tab.push_back(mk_push(0));                          // bottom row
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 1, 1, 8'h80));
        dir_tab.push_back(mk_push(65535));                      // clamped to top row
        dir_tab.push_back(mk_read(ssc_pkg::SCREEN_COLUMNS - 1, 1, 8'h01));
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 2, 1, 8'h80));
        dir_tab.push_back(mk_cfg(ssc_pkg::CFG_FULL_SCALE, 0));  // zero scale saturates
        dir_tab.push_back(mk_push(5));
        dir_tab.push_back(mk_read(ssc_pkg::SCREEN_COLUMNS - 2, 1, 8'h01));
        dir_tab.push_back(mk_read(ssc_pkg::SCREEN_COLUMNS - 1, 1, 8'h01));
        dir_tab.push_back(mk_cfg(ssc_pkg::CFG_FULL_SCALE, 65535));
        dir_tab.push_back(mk_push(65535));
        dir_tab.push_back(mk_push(1023));
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 1, 1, 8'h80));
        dir_tab.push_back(mk_cfg(ssc_pkg::CFG_PLOT_REGION, 1)); // top half
        dir_tab.push_back(mk_push(0));
        dir_tab.push_back(mk_read(ssc_pkg::TOP_LAST, 1, 8'h80));
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 1, 1, 8'h80)); // bottom left alone
        dir_tab.push_back(mk_cfg(ssc_pkg::CFG_PLOT_REGION, 2)); // bottom half
        dir_tab.push_back(mk_push(0));
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 1, 1, 8'h80));
        dir_tab.push_back(mk_push(65535));
        dir_tab.push_back(mk_read(ssc_pkg::BOTTOM_FIRST + ssc_pkg::SCREEN_COLUMNS - 1,
                                  0, 8'h00));
        dir_tab.push_back(mk_read(ssc_pkg::STORE_BYTES - 2, 0, 8'h00));
        dir_tab.push_back(mk_cfg(ssc_pkg::CFG_PLOT_REGION, 3)); // unused code acts as top
        dir_tab.push_back(mk_push(65535));
        dir_tab.push_back(mk_read(ssc_pkg::SCREEN_COLUMNS - 1, 1, 8'h01));
    endtask

    function automatic ssc_pkg::sample_t pick_sample();
        int unsigned top;
        case ($urandom_range(0, 7))
            0, 1: pick_sample = ssc_pkg::sample_t'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0:       pick_sample = '0;
                    1:       pick_sample = '1;
                    2:       pick_sample = ssc_pkg::sample_t'(shadow_scale);
                    default: pick_sample = ssc_pkg::sample_t'(shadow_scale - 1);
                endcase
            end
            default: begin
                top = int'(shadow_scale) + int'(shadow_scale) / 8;
                if (top > 65535)
                    top = 65535;
                pick_sample = ssc_pkg::sample_t'($urandom_range(0, top));
            end
        endcase
    endfunction

    // Bias reads toward the freshly drawn right-hand columns
    function automatic rd_addr_t pick_addr();
        int unsigned page, col;
        if ($urandom_range(0, 1) == 0) begin
            page = $urandom_range(0, ssc_pkg::STORE_PAGES - 1);
            col  = ssc_pkg::SCREEN_COLUMNS - 1 - $urandom_range(0, 47);
            pick_addr = rd_addr_t'(page * ssc_pkg::SCREEN_COLUMNS + col);
        end else begin
            pick_addr = rd_addr_t'($urandom);
        end
    endfunction

    task automatic start_phase(input int en, input int scale, input int region,
                               input int src, input int sink);
        settle_block();
        write_reg(ssc_pkg::CFG_PLOT_ENABLE, cfg_data_t'(en));
        write_reg(ssc_pkg::CFG_FULL_SCALE, cfg_data_t'(scale));
        write_reg(ssc_pkg::CFG_PLOT_REGION, cfg_data_t'(region));
        src_pct  = src;
        sink_pct = sink;
        settings_run++;
    endtask

    task automatic run_phase(input int n_items);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 35)
                send_item(REQ_PUSH, pick_sample(), rd_addr_t'($urandom), 0, 8'h00);
            else
                send_item(ssc_pkg::REQ_READ, ssc_pkg::sample_t'($urandom), pick_addr(),
                          0, 8'h00);
        end
    endtask

    // Result sink: random stall bursts
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready   <= 1'b0;
            sink_hold  = sink_hold - 1;
        end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
            m_ready   <= 1'b0;
            sink_hold  = $urandom_range(0, 17);
        end else begin
            m_ready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (read_byte_q.size() == 0) begin
                report_mismatch("read byte with no read pending", m_read_byte, 0);
            end else begin
                want_byte = read_byte_q.pop_front();
                if (m_read_byte !== want_byte)
                    report_mismatch("read_byte", m_read_byte, want_byte);
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel and no config write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ssc_pkg::STORE_BYTES; i++)
            fb_model[i] = '0;
        shadow_enable = 1'b0;
        shadow_scale  = cfg_data_t'(ssc_pkg::FULL_SCALE_RESET);
        shadow_region = ssc_pkg::REGION_FULL;
        build_directed();

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                send_item(dir_tab[i].req, dir_tab[i].smp, dir_tab[i].addr,
                          dir_tab[i].has_exp, dir_tab[i].exp_byte);
            end
        end

        start_phase(1, 4096, 0, 20, 20);
        run_phase(PHASE_ITEMS);
        start_phase(1, 1, 1, 0, 30);
        run_phase(PHASE_ITEMS);
        start_phase(1, 65535, 2, 30, 0);
        run_phase(PHASE_ITEMS);
        start_phase(0, 777, 0, 25, 25);
        run_phase(PHASE_ITEMS / 2);
        start_phase(1, 0, 3, 15, 15);
        run_phase(PHASE_ITEMS);
        start_phase(1, $urandom_range(1, 65535), $urandom_range(0, 3), 40, 40);
        run_phase(PHASE_ITEMS);
        start_phase(1, $urandom_range(1, 300), 2, 10, 10);
        run_phase(PHASE_ITEMS);
        start_phase(1, $urandom_range(1, 65535), 1, 20, 20);
        run_phase(PHASE_ITEMS);
        // no idling from here on
        start_phase(1, $urandom_range(1, 8191), 0, 0, 0);
        run_phase(PHASE_ITEMS / 2);
        settle_block();

        $display("covered %0d reads and %0d pushes (%0d drawn) across %0d register settings",
                 reads_sent, pushes_sent, pushes_drawn, settings_run);
        $display("%0d read bytes checked, %0d mismatches", results_seen, err_count);
        if (err_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: scrolling_strip_chart_framebuffer.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_row_div.sv
rtl/core/ssc_frame_store.sv
rtl/core/scrolling_strip_chart_framebuffer.sv
tb/testbench.sv
